[rtl/biquad_cascade_filter_assert.svh]
// ---------------------------------------------------------------------------
// Biquad cascade filter assertion macros
// Implication checks clocked on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef BIQUAD_CASCADE_FILTER_ASSERT_SVH
`define BIQUAD_CASCADE_FILTER_ASSERT_SVH

`ifndef SYNTHESIS
`define BCF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bcf assertion failed");
`define BCF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bcf assertion failed");
`else
`define BCF_ASSERT_IMP(label, ante, cons)
`define BCF_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/bcf_pkg.sv]
// ---------------------------------------------------------------------------
// Biquad cascade filter package
// Widths, register indexes and saturation helpers.
// ---------------------------------------------------------------------------
package bcf_pkg;

    localparam int SAMPLE_W           = 16;
    localparam int COEF_W             = 32;
    localparam int STAGE_COUNT_W      = 7;
    localparam int CFG_INDEX_W        = 3;
    localparam int CFG_DATA_W         = 32;
    localparam int STATE_W            = 48;
    localparam int FRAC_BITS          = 30;
    localparam int LO_W               = 16;
    localparam int MUL_A_W            = STATE_W - LO_W + 1;
    localparam int PROD_W             = MUL_A_W + COEF_W;
    localparam int ACC_W              = STATE_W + COEF_W;
    localparam int M_W                = ACC_W - FRAC_BITS;
    localparam int SUM_W              = M_W + 2;
    localparam int DEFAULT_MAX_STAGES = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED0  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED1  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_FEED2  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_BACK1  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_COEF_BACK2  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_STAGE_COUNT = 3'd5;

    localparam logic signed [COEF_W-1:0] COEF_ONE = 32'sh4000_0000;

    localparam logic signed [SUM_W-1:0] SAT_HI =
        {{(SUM_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [SUM_W-1:0] SAT_LO =
        {{(SUM_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

    localparam int OUT_Q_W = STATE_W + 1 - FRAC_BITS;
    localparam logic signed [OUT_Q_W-1:0] OUT_HI =
        {{(OUT_Q_W-SAMPLE_W+1){1'b0}}, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [OUT_Q_W-1:0] OUT_LO =
        {{(OUT_Q_W-SAMPLE_W+1){1'b1}}, {(SAMPLE_W-1){1'b0}}};

    function automatic logic signed [STATE_W-1:0] sat_state(
        input logic signed [SUM_W-1:0] v
    );
        logic signed [STATE_W-1:0] r;
        if (v > SAT_HI)
        begin
            r = SAT_HI[STATE_W-1:0];
        end
        else if (v < SAT_LO)
        begin
            r = SAT_LO[STATE_W-1:0];
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // round half up to integer, clamp to 16 bits
    function automatic logic signed [SAMPLE_W-1:0] round_sample(
        input logic signed [STATE_W-1:0] x
    );
        logic signed [STATE_W:0]     rx;
        logic signed [OUT_Q_W-1:0]   q;
        logic signed [SAMPLE_W-1:0]  r;
        rx = (STATE_W+1)'(x) + ((STATE_W+1)'(1) <<< (FRAC_BITS - 1));
        q  = rx[STATE_W:FRAC_BITS];
        if (q > OUT_HI)
        begin
            r = OUT_HI[SAMPLE_W-1:0];
        end
        else if (q < OUT_LO)
        begin
            r = OUT_LO[SAMPLE_W-1:0];
        end
        else
        begin
            r = q[SAMPLE_W-1:0];
        end
        return r;
    endfunction

endpackage

[rtl/biquad_cascade_filter.sv]
// ---------------------------------------------------------------------------
// Biquad cascade filter
// Cascade of identical TDF-II biquad sections on one shared 33x32 multiplier.
// ---------------------------------------------------------------------------
//  channel  | signals                                  | dir
//  ---------+------------------------------------------+-----
//  input    | in_valid/in_ready, sample_in, block_end_in | in
//  output   | out_valid/out_ready, sample_out, block_end_out | out
//  config   | cfg_wr_en, cfg_index, cfg_data           | in
//
//  One transaction runs N sections in turn, N = min(stage_count, MAX_STAGES).
//  Each section issues 10 passes (low 16 bits unsigned, high bits signed, for
//  five multiplies) to the multiplier, then drains the pipeline and writes back.
//  Section state lives in one RAM; per-entry valid bits cleared at reset stand
//  in for the all-zero reset value, so there is no clearing pass.
//  The result sits in an output register; the next input is taken only in idle,
//  so it waits while the sections run and while that register is still full.
// ---------------------------------------------------------------------------
module biquad_cascade_filter
    import bcf_pkg::*;
#(
    parameter int MAX_STAGES = DEFAULT_MAX_STAGES
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic signed [SAMPLE_W-1:0] sample_in,
    input  logic                       block_end_in,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic signed [SAMPLE_W-1:0] sample_out,
    output logic                       block_end_out,
    input  logic                       cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0]     cfg_index,
    input  logic [CFG_DATA_W-1:0]      cfg_data
);

`include "biquad_cascade_filter_assert.svh"

    localparam int IDX_W = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int CNT_W = $clog2(MAX_STAGES + 1);
    localparam int CMP_W = (CNT_W > STAGE_COUNT_W) ? CNT_W : STAGE_COUNT_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [3:0] STEP_Y     = 4'd3;
    localparam logic [3:0] STEP_T1    = 4'd5;
    localparam logic [3:0] STEP_T2    = 4'd7;
    localparam logic [3:0] STEP_T1_FB = 4'd9;
    localparam logic [3:0] STEP_T2_FB = 4'd11;
    localparam logic [3:0] STEP_WB    = 4'd12;

    localparam logic [2:0] OP_FEED0 = 3'd0;
    localparam logic [2:0] OP_FEED1 = 3'd1;
    localparam logic [2:0] OP_FEED2 = 3'd2;
    localparam logic [2:0] OP_BACK1 = 3'd3;
    localparam logic [2:0] OP_BACK2 = 3'd4;

    localparam logic signed [ACC_W-1:0] HALF_ACC = ACC_W'(1) <<< (FRAC_BITS - 1);

    logic signed [COEF_W-1:0]        coef_feed0_reg;
    logic signed [COEF_W-1:0]        coef_feed1_reg;
    logic signed [COEF_W-1:0]        coef_feed2_reg;
    logic signed [COEF_W-1:0]        coef_back1_reg;
    logic signed [COEF_W-1:0]        coef_back2_reg;
    logic [STAGE_COUNT_W-1:0]        stage_count_reg;

    logic [1:0]                      state_reg;
    logic [3:0]                      cyc_reg;
    logic [IDX_W-1:0]                sec_reg;
    logic                            block_end_reg;
    logic signed [STATE_W-1:0]       x_reg;
    logic signed [STATE_W-1:0]       y_reg;
    logic signed [SUM_W-1:0]         t1_reg;
    logic signed [SUM_W-1:0]         t2_reg;
    logic signed [PROD_W-1:0]        prod_reg;
    logic signed [ACC_W-1:0]         acc_reg;

    logic [2*STATE_W-1:0]            delay_mem [MAX_STAGES];
    logic [2*STATE_W-1:0]            rd_data_reg;
    logic [MAX_STAGES-1:0]           valid_reg;
    logic                            rd_valid_reg;

    logic                            out_valid_reg;
    logic signed [SAMPLE_W-1:0]      sample_out_reg;
    logic                            block_end_out_reg;

    logic [CMP_W-1:0]                sc_ext;
    logic [CMP_W-1:0]                max_ext;
    logic [CNT_W-1:0]                n_eff;
    logic                            last_sec;
    logic                            mem_we;
    logic                            in_fire;
    logic                            out_load;

    logic [2:0]                      op;
    logic signed [STATE_W-1:0]       mul_v;
    logic signed [MUL_A_W-1:0]       mul_a;
    logic signed [COEF_W-1:0]        mul_c;
    logic signed [PROD_W-1:0]        prod_next;
    logic signed [M_W-1:0]           m_val;
    logic signed [STATE_W-1:0]       d1;
    logic signed [STATE_W-1:0]       d2;

    assign sc_ext   = CMP_W'(stage_count_reg);
    assign max_ext  = CMP_W'(MAX_STAGES);
    assign n_eff    = (sc_ext > max_ext) ? CNT_W'(max_ext) : CNT_W'(sc_ext);
    assign last_sec = (CNT_W'(sec_reg) + CNT_W'(1)) == n_eff;

    assign in_ready = (state_reg == ST_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_load = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign mem_we   = (state_reg == ST_RUN) && (cyc_reg == STEP_WB);

    assign out_valid     = out_valid_reg;
    assign sample_out    = sample_out_reg;
    assign block_end_out = block_end_out_reg;

    // shared multiplier: low half unsigned, high half signed
    always_comb
    begin
        op    = cyc_reg[3:1];
        mul_v = (op < OP_BACK1) ? x_reg : y_reg;
        if (cyc_reg[0])
        begin
            mul_a = MUL_A_W'(mul_v >>> LO_W);
        end
        else
        begin
            mul_a = {{(MUL_A_W-LO_W){1'b0}}, mul_v[LO_W-1:0]};
        end
        unique case (op)
            OP_FEED0: mul_c = coef_feed0_reg;
            OP_FEED1: mul_c = coef_feed1_reg;
            OP_FEED2: mul_c = coef_feed2_reg;
            OP_BACK1: mul_c = coef_back1_reg;
            OP_BACK2: mul_c = coef_back2_reg;
            default:  mul_c = coef_back2_reg;
        endcase
        prod_next = mul_a * mul_c;
    end

    assign m_val = acc_reg[ACC_W-1:FRAC_BITS];
    assign d1    = rd_valid_reg ? rd_data_reg[2*STATE_W-1:STATE_W] : '0;
    assign d2    = rd_valid_reg ? rd_data_reg[STATE_W-1:0] : '0;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_feed0_reg  <= COEF_ONE;
            coef_feed1_reg  <= '0;
            coef_feed2_reg  <= '0;
            coef_back1_reg  <= '0;
            coef_back2_reg  <= '0;
            stage_count_reg <= STAGE_COUNT_W'(1);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_COEF_FEED0:  coef_feed0_reg  <= cfg_data;
                REG_COEF_FEED1:  coef_feed1_reg  <= cfg_data;
                REG_COEF_FEED2:  coef_feed2_reg  <= cfg_data;
                REG_COEF_BACK1:  coef_back1_reg  <= cfg_data;
                REG_COEF_BACK2:  coef_back2_reg  <= cfg_data;
                REG_STAGE_COUNT: stage_count_reg <= cfg_data[STAGE_COUNT_W-1:0];
                default:         ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            cyc_reg   <= '0;
            sec_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        cyc_reg   <= '0;
                        sec_reg   <= '0;
                        state_reg <= (n_eff == '0) ? ST_DONE : ST_RUN;
                    end
                end
                ST_RUN:
                begin
                    if (cyc_reg == STEP_WB)
                    begin
                        cyc_reg <= '0;
                        if (last_sec)
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            sec_reg <= sec_reg + IDX_W'(1);
                        end
                    end
                    else
                    begin
                        cyc_reg <= cyc_reg + 4'd1;
                    end
                end
                ST_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        if (cyc_reg[0])
        begin
            acc_reg <= ACC_W'(prod_reg) + HALF_ACC;
        end
        else
        begin
            acc_reg <= acc_reg + (ACC_W'(prod_reg) <<< LO_W);
        end

        if (in_fire)
        begin
            x_reg         <= {{(STATE_W-SAMPLE_W-FRAC_BITS){sample_in[SAMPLE_W-1]}},
                              sample_in, {FRAC_BITS{1'b0}}};
            block_end_reg <= block_end_in;
        end
        else if (state_reg == ST_RUN)
        begin
            unique case (cyc_reg)
                STEP_Y:     y_reg  <= sat_state(SUM_W'(m_val) + SUM_W'(d1));
                STEP_T1:    t1_reg <= SUM_W'(m_val) + SUM_W'(d2);
                STEP_T2:    t2_reg <= SUM_W'(m_val);
                STEP_T1_FB: t1_reg <= t1_reg - SUM_W'(m_val);
                STEP_T2_FB: t2_reg <= t2_reg - SUM_W'(m_val);
                STEP_WB:    x_reg  <= y_reg;
                default:    ;
            endcase
        end
    end

    // section state RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            delay_mem[sec_reg] <= {sat_state(t1_reg), sat_state(t2_reg)};
        end
        rd_data_reg <= delay_mem[sec_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                valid_reg[sec_reg] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[sec_reg];
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            sample_out_reg    <= round_sample(x_reg);
            block_end_out_reg <= block_end_reg;
        end
    end

    `BCF_ASSERT_NEXT(a_accept_starts, in_fire, state_reg != ST_IDLE)
    `BCF_ASSERT_IMP(a_step_range, state_reg == ST_RUN, cyc_reg <= STEP_WB)
    `BCF_ASSERT_IMP(a_sec_range, state_reg == ST_RUN, CNT_W'(sec_reg) < n_eff)
    `BCF_ASSERT_IMP(a_out_from_done, $rose(out_valid_reg), $past(state_reg) == ST_DONE)

endmodule

[bench/tb_biquad_cascade_filter.sv]
// ---------------------------------------------------------------------------
// Biquad cascade filter testbench
// Drives samples through the valid/ready input and compares every output
// transaction with a bit-exact fixed-point model of the TDF-II cascade.
// Coefficients and stage counts change between drained phases. Both sides
// idle at random, and the output is held off once to back up the pipeline.
// ---------------------------------------------------------------------------
module tb_biquad_cascade_filter;
    import bcf_pkg::*;

    localparam int RANDOM_ITEMS = 1080;
    localparam int HOLD_CYCLES  = 600;
    localparam int HOLD_PHASE   = 2;
    localparam int BURST_PHASE  = 4;
    localparam int IDLE_PCT     = 23;

    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

    localparam logic signed [95:0] HALF_Q30  = 96'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [95:0] STATE_MAX = (96'sd1 <<< (STATE_W - 1)) - 96'sd1;
    localparam logic signed [95:0] STATE_MIN = -(96'sd1 <<< (STATE_W - 1));

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                block_end;
    } audio_frame_t;

    logic                       clk;
    logic                       rst_n = 1'b0;
    logic                       in_valid = 1'b0;
    logic                       in_ready;
    logic signed [SAMPLE_W-1:0] sample_in = '0;
    logic                       block_end_in = 1'b0;
    logic                       out_valid;
    logic                       out_ready = 1'b0;
    logic signed [SAMPLE_W-1:0] sample_out;
    logic                       block_end_out;
    logic                       cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0]     cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    audio_frame_t stimulus_q[$];
    audio_frame_t filtered_q[$];

    logic signed [COEF_W-1:0]   gain_b0;
    logic signed [COEF_W-1:0]   gain_b1;
    logic signed [COEF_W-1:0]   gain_b2;
    logic signed [COEF_W-1:0]   gain_a1;
    logic signed [COEF_W-1:0]   gain_a2;
    logic [STAGE_COUNT_W-1:0]   stages_cfg;
    logic signed [STATE_W-1:0]  delay1 [DEFAULT_MAX_STAGES];
    logic signed [STATE_W-1:0]  delay2 [DEFAULT_MAX_STAGES];

    int idle_pct = IDLE_PCT;
    bit hold_request = 1'b0;
    int hold_left = 0;
    int mismatch_count = 0;
    int results_checked = 0;
    int samples_sent = 0;
    int walk_level = 0;

    biquad_cascade_filter dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .sample_in     (sample_in),
        .block_end_in  (block_end_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .sample_out    (sample_out),
        .block_end_out (block_end_out),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #10_000_000;
        $display("Timeout with %0d results still outstanding", filtered_q.size());
        $display("** biquad_cascade_filter: FAILED **");
        $finish;
    end

    // floor((v*c + 2^29) / 2^30), exact
    function automatic logic signed [95:0] q30_mul(
        input logic signed [STATE_W-1:0] v,
        input logic signed [COEF_W-1:0]  c
    );
        logic signed [95:0] wide_v;
        logic signed [95:0] wide_c;
        wide_v = v;
        wide_c = c;
        return (wide_v * wide_c + HALF_Q30) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [STATE_W-1:0] clamp48(input logic signed [95:0] v);
        logic signed [STATE_W-1:0] r;
        if (v > STATE_MAX)
        begin
            r = STATE_MAX[STATE_W-1:0];
        end
        else if (v < STATE_MIN)
        begin
            r = STATE_MIN[STATE_W-1:0];
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // advances the section state and returns the filtered sample
    function automatic audio_frame_t run_cascade(input audio_frame_t in_frame);
        logic signed [STATE_W-1:0] x;
        logic signed [STATE_W-1:0] y;
        logic signed [STATE_W-1:0] old2;
        logic signed [95:0]        wide;
        int                        n;
        audio_frame_t              res;
        wide = $signed(in_frame.sample);
        wide = wide <<< FRAC_BITS;
        x = wide[STATE_W-1:0];
        n = (stages_cfg > DEFAULT_MAX_STAGES) ? DEFAULT_MAX_STAGES : int'(stages_cfg);
        for (int j = 0; j < n; j++)
        begin
            old2 = delay2[j];
            y = clamp48(q30_mul(x, gain_b0) + delay1[j]);
            delay1[j] = clamp48(q30_mul(x, gain_b1) + old2 - q30_mul(y, gain_a1));
            delay2[j] = clamp48(q30_mul(x, gain_b2) - q30_mul(y, gain_a2));
            x = y;
        end
        wide = x;
        wide = (wide + HALF_Q30) >>> FRAC_BITS;
        if (wide > 96'sd32767)
        begin
            res.sample = 16'h7FFF;
        end
        else if (wide < -96'sd32768)
        begin
            res.sample = 16'h8000;
        end
        else
        begin
            res.sample = wide[SAMPLE_W-1:0];
        end
        res.block_end = in_frame.block_end;
        return res;
    endfunction

    function automatic int nominal_coef(input bit highpass, input int r);
        int c;
        case (r)
            0: c = highpass ? 686013651 : 72477573;
            1: c = highpass ? -1372027302 : 144955146;
            2: c = highpass ? 686013651 : 72477573;
            3: c = -1227286905;
            default: c = 443240625;
        endcase
        return c;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        int r;
        int s;
        r = $urandom_range(0, 19);
        if (r < 8)
        begin
            s = $urandom;
        end
        else if (r < 14)
        begin
            walk_level = walk_level + int'($urandom_range(0, 4000)) - 2000;
            if (walk_level > 32767)
            begin
                walk_level = 32767;
            end
            if (walk_level < -32768)
            begin
                walk_level = -32768;
            end
            s = walk_level;
        end
        else if (r < 17)
        begin
            s = int'($urandom_range(0, 2000)) - 1000;
        end
        else
        begin
            s = (r == 17) ? 32767 : -32768;
        end
        return s[SAMPLE_W-1:0];
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("[%0t] mismatch #%0d: %s", $realtime, mismatch_count, what);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        case (idx)
            REG_COEF_FEED0:  gain_b0 = data;
            REG_COEF_FEED1:  gain_b1 = data;
            REG_COEF_FEED2:  gain_b2 = data;
            REG_COEF_BACK1:  gain_a1 = data;
            REG_COEF_BACK2:  gain_a2 = data;
            REG_STAGE_COUNT: stages_cfg = data[STAGE_COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic push_frame(input logic [SAMPLE_W-1:0] s, input logic last);
        audio_frame_t f;
        f.sample = s;
        f.block_end = last;
        stimulus_q.push_back(f);
    endtask

    task automatic wait_drained();
        while (stimulus_q.size() != 0 || in_valid || filtered_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    // input driver
    always @(posedge clk or negedge rst_n)
    begin : drive_input
        audio_frame_t nxt;
        audio_frame_t sent;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                sent.sample = sample_in;
                sent.block_end = block_end_in;
                filtered_q.push_back(run_cascade(sent));
                samples_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (stimulus_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
                begin
                    nxt = stimulus_q.pop_front();
                    in_valid     <= 1'b1;
                    sample_in    <= nxt.sample;
                    block_end_in <= nxt.block_end;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // output ready, with a single long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            hold_left = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_left = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(0, 99) >= idle_pct);
            end
        end
    end

    // output monitor
    always @(posedge clk)
    begin : check_output
        audio_frame_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (filtered_q.size() == 0)
            begin
                report_mismatch($sformatf("unexpected output transaction, sample %0d",
                                          sample_out));
            end
            else
            begin
                want = filtered_q.pop_front();
                results_checked++;
                if (sample_out !== want.sample)
                begin
                    report_mismatch($sformatf("sample_out %0d, expected %0d",
                                              sample_out, $signed(want.sample)));
                end
                if (block_end_out !== want.block_end)
                begin
                    report_mismatch($sformatf("block_end_out %b, expected %b",
                                              block_end_out, want.block_end));
                end
            end
        end
    end

    initial
    begin : main_seq
        logic [CFG_DATA_W-1:0] coef_pick [5];
        logic [CFG_DATA_W-1:0] data;
        int                    style;
        int                    stg;
        int                    eff;
        int                    phase_len;
        int                    phase_idx;
        int                    random_queued;
        int                    max_eff;
        int                    c;

        phase_idx = 0;
        random_queued = 0;
        max_eff = 0;
        gain_b0 = COEF_ONE;
        gain_b1 = '0;
        gain_b2 = '0;
        gain_a1 = '0;
        gain_a2 = '0;
        stages_cfg = 7'd1;
        for (int j = 0; j < DEFAULT_MAX_STAGES; j++)
        begin
            delay1[j] = '0;
            delay2[j] = '0;
        end

        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity single section
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h8000, 1'b1);
        push_frame(16'h0000, 1'b0);
        push_frame(16'hFFFF, 1'b0);
        push_frame(16'h0001, 1'b0);
        push_frame(16'h5555, 1'b1);
        push_frame(16'hAAAA, 1'b0);
        wait_drained();

        // zero stages, upper data bits set
        write_reg(REG_STAGE_COUNT, 32'hFFFF_FF80);
        push_frame(16'h3039, 1'b0);
        push_frame(16'h8000, 1'b0);
        push_frame(16'h7FFF, 1'b1);
        wait_drained();

        // extreme coefficients, count above the maximum
        write_reg(REG_COEF_FEED0, 32'h7FFF_FFFF);
        write_reg(REG_COEF_FEED1, 32'h8000_0000);
        write_reg(REG_COEF_FEED2, 32'h7FFF_FFFF);
        write_reg(REG_COEF_BACK1, 32'h8000_0000);
        write_reg(REG_COEF_BACK2, 32'h7FFF_FFFF);
        write_reg(REG_STAGE_COUNT, 32'h0000_007F);
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h8000, 1'b1);
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h8000, 1'b1);
        wait_drained();

        // spare indexes must be ignored
        write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
        write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
        write_reg(REG_COEF_FEED0, 32'h8000_0000);
        write_reg(REG_COEF_FEED1, 32'h7FFF_FFFF);
        write_reg(REG_COEF_FEED2, 32'h8000_0000);
        write_reg(REG_COEF_BACK1, 32'h7FFF_FFFF);
        write_reg(REG_COEF_BACK2, 32'h8000_0000);
        write_reg(REG_STAGE_COUNT, 32'h0000_0085);
        push_frame(16'h8000, 1'b0);
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h0001, 1'b0);
        push_frame(16'hFFFF, 1'b1);
        wait_drained();

        // short lowpass, then all sections: untouched ones kept their state
        for (int r = 0; r < 5; r++)
        begin
            coef_pick[r] = nominal_coef(1'b0, r);
        end
        write_reg(REG_COEF_FEED0, coef_pick[0]);
        write_reg(REG_COEF_FEED1, coef_pick[1]);
        write_reg(REG_COEF_FEED2, coef_pick[2]);
        write_reg(REG_COEF_BACK1, coef_pick[3]);
        write_reg(REG_COEF_BACK2, coef_pick[4]);
        write_reg(REG_STAGE_COUNT, 32'h0000_0002);
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h7FFF, 1'b0);
        push_frame(16'h7FFF, 1'b1);
        wait_drained();
        write_reg(REG_STAGE_COUNT, 32'h0000_0040);
        push_frame(16'h1000, 1'b0);
        push_frame(16'hF000, 1'b0);
        push_frame(16'h0000, 1'b1);
        max_eff = DEFAULT_MAX_STAGES;

        while (random_queued < RANDOM_ITEMS)
        begin
            wait_drained();
            style = $urandom_range(0, 9);
            for (int r = 0; r < 5; r++)
            begin
                case (style)
                    0, 1, 2, 3:
                        c = nominal_coef(1'b0, r) + int'($urandom_range(0, 65535)) - 32768;
                    4, 5:
                        c = nominal_coef(1'b1, r) + int'($urandom_range(0, 65535)) - 32768;
                    6, 7:
                        c = $urandom;
                    8:
                        c = int'($urandom_range(0, 32'h3FFF_FFFF)) - 32'sh2000_0000;
                    default:
                    begin
                        case ($urandom_range(0, 3))
                            0: c = 32'h7FFF_FFFF;
                            1: c = 32'h8000_0000;
                            2: c = 0;
                            default: c = COEF_ONE;
                        endcase
                    end
                endcase
                coef_pick[r] = c;
            end
            case ($urandom_range(0, 19))
                0: stg = 0;
                1: stg = DEFAULT_MAX_STAGES;
                2: stg = $urandom_range(DEFAULT_MAX_STAGES + 1, 127);
                default: stg = $urandom_range(1, 6);
            endcase
            if (phase_idx == HOLD_PHASE || phase_idx == BURST_PHASE)
            begin
                stg = 3;
            end
            if ($urandom_range(0, 6) != 0) write_reg(REG_COEF_FEED0, coef_pick[0]);
            if ($urandom_range(0, 6) != 0) write_reg(REG_COEF_FEED1, coef_pick[1]);
            if ($urandom_range(0, 6) != 0) write_reg(REG_COEF_FEED2, coef_pick[2]);
            if ($urandom_range(0, 6) != 0) write_reg(REG_COEF_BACK1, coef_pick[3]);
            if ($urandom_range(0, 6) != 0) write_reg(REG_COEF_BACK2, coef_pick[4]);
            if ($urandom_range(0, 3) == 0)
            begin
                write_reg($urandom_range(0, 1) ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
            end
            if ($urandom_range(0, 5) != 0 || phase_idx == HOLD_PHASE
                || phase_idx == BURST_PHASE)
            begin
                data = $urandom;
                data[STAGE_COUNT_W-1:0] = STAGE_COUNT_W'(stg);
                write_reg(REG_STAGE_COUNT, data);
            end

            eff = (stages_cfg > DEFAULT_MAX_STAGES) ? DEFAULT_MAX_STAGES : int'(stages_cfg);
            if (eff > max_eff)
            begin
                max_eff = eff;
            end
            phase_len = (eff >= 32) ? $urandom_range(6, 12) : $urandom_range(30, 90);
            if (phase_idx == BURST_PHASE)
            begin
                phase_len = 150;
            end
            idle_pct = (phase_idx == BURST_PHASE) ? 0 : IDLE_PCT;
            if (phase_idx == HOLD_PHASE)
            begin
                hold_request = 1'b1;
            end

            for (int k = 0; k < phase_len; k++)
            begin
                // sender pause mid-phase until everything has come back
                if (phase_idx % 5 == 3 && k == phase_len / 2)
                begin
                    wait_drained();
                end
                push_frame(random_sample(), $urandom_range(0, 7) == 0);
                random_queued++;
            end
            phase_idx++;
        end

        wait_drained();
        repeat (20) @(posedge clk);
        $display("Checked %0d of %0d samples across %0d random settings plus directed cases,",
                 results_checked, samples_sent, phase_idx);
        $display("stage counts 0 through %0d, saturating coefficients and output back-pressure.",
                 max_eff);
        if (mismatch_count == 0)
        begin
            $display("** biquad_cascade_filter: PASSED **");
        end
        else
        begin
            $display("** biquad_cascade_filter: FAILED **");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/bcf_pkg.sv
rtl/biquad_cascade_filter.sv
bench/tb_biquad_cascade_filter.sv
